### hdl/ssfs_pkg.sv
// Shared types, constants and the glyph table of the seven-segment frame sequencer.
package ssfs_pkg;

  localparam int unsigned QueueDepth = 2;

  // request kinds as they arrive on the input stream
  typedef enum logic [2:0] {
    KIND_DIGIT       = 3'd0,
    KIND_RAW_ONE     = 3'd1,
    KIND_RAW_FOUR    = 3'd2,
    KIND_REFRESH     = 3'd3,
    KIND_CLEAR       = 3'd4,
    KIND_SCROLL_DIG  = 3'd5,
    KIND_SCROLL_RAW  = 3'd6
  } kind_e;

  // classified operations for the back end
  typedef enum logic [1:0] {
    OP_SINGLE = 2'd0,
    OP_QUAD   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_SCROLL = 2'd3
  } op_e;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_START_ADDR = 2'd1,
    REG_POINT_MASK = 2'd2
  } reg_e;

  localparam logic [2:0] BrightnessReset = 3'd0;
  localparam logic [7:0] StartAddrReset  = 8'hc0;
  localparam logic [7:0] PointMaskReset  = 8'h00;

  localparam logic [7:0] CmdDataFixed = 8'h44;
  localparam logic [7:0] CmdDataAuto  = 8'h40;
  localparam logic [7:0] CmdAddrBase  = 8'hc0;
  localparam logic [7:0] CmdCtrlBase  = 8'h88;

  typedef struct packed {
    op_e             op;
    logic            store;  // quad frame writes the four bytes first
    logic [1:0]      pos;
    logic [7:0]      nb;
    logic [3:0][7:0] segs;
  } cmd_t;

  typedef struct packed {
    logic [2:0] brightness;
    logic [7:0] start_address;
    logic [7:0] point_mask;
  } cfg_t;

  function automatic logic [7:0] glyph(input logic [3:0] code);
    logic [7:0] g;
    case (code)
      4'd0:    g = 8'h3f;
      4'd1:    g = 8'h06;
      4'd2:    g = 8'h5b;
      4'd3:    g = 8'h4f;
      4'd4:    g = 8'h66;
      4'd5:    g = 8'h6d;
      4'd6:    g = 8'h7d;
      4'd7:    g = 8'h07;
      4'd8:    g = 8'h7f;
      4'd9:    g = 8'h6f;
      4'd11:   g = 8'h40;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

### hdl/ssfs_regs.sv
// Configuration registers behind the APB-style port.
module ssfs_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output ssfs_pkg::cfg_t     cfg_o
);

  ssfs_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  ssfs_pkg::reg_e sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = ssfs_pkg::reg_e'(paddr[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        ssfs_pkg::REG_BRIGHTNESS: cfg_d.brightness    = pwdata[2:0];
        ssfs_pkg::REG_START_ADDR: cfg_d.start_address = pwdata[7:0];
        ssfs_pkg::REG_POINT_MASK: cfg_d.point_mask    = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      ssfs_pkg::REG_BRIGHTNESS: prdata = {29'd0, cfg_q.brightness};
      ssfs_pkg::REG_START_ADDR: prdata = {24'd0, cfg_q.start_address};
      ssfs_pkg::REG_POINT_MASK: prdata = {24'd0, cfg_q.point_mask};
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brightness    <= ssfs_pkg::BrightnessReset;
      cfg_q.start_address <= ssfs_pkg::StartAddrReset;
      cfg_q.point_mask    <= ssfs_pkg::PointMaskReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/ssfs_front.sv
// Front end: takes requests, classifies them into back-end commands.
module ssfs_front (
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [2:0]        s_kind_i,
  input  logic [1:0]        s_pos_i,
  input  logic [3:0]        s_digit_i,
  input  logic [3:0][7:0]   s_segs_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output ssfs_pkg::cmd_t    q_cmd_o
);

  logic       known;
  logic [7:0] gl;

  assign gl         = ssfs_pkg::glyph(s_digit_i);
  assign s_tready_o = !q_full_i;

  always_comb begin
    known         = 1'b1;
    q_cmd_o.op    = ssfs_pkg::OP_SINGLE;
    q_cmd_o.store = 1'b0;
    q_cmd_o.pos   = s_pos_i;
    q_cmd_o.nb    = s_segs_i[0];
    q_cmd_o.segs  = s_segs_i;
    unique case (ssfs_pkg::kind_e'(s_kind_i))
      ssfs_pkg::KIND_DIGIT:      q_cmd_o.nb = gl;
      ssfs_pkg::KIND_RAW_ONE:    ;
      ssfs_pkg::KIND_RAW_FOUR: begin
        q_cmd_o.op    = ssfs_pkg::OP_QUAD;
        q_cmd_o.store = 1'b1;
      end
      ssfs_pkg::KIND_REFRESH:    q_cmd_o.op = ssfs_pkg::OP_QUAD;
      ssfs_pkg::KIND_CLEAR:      q_cmd_o.op = ssfs_pkg::OP_CLEAR;
      ssfs_pkg::KIND_SCROLL_DIG: begin
        q_cmd_o.op = ssfs_pkg::OP_SCROLL;
        q_cmd_o.nb = gl;
      end
      ssfs_pkg::KIND_SCROLL_RAW: q_cmd_o.op = ssfs_pkg::OP_SCROLL;
      default:                   known = 1'b0;  // unused kind: dropped
    endcase
  end

  assign q_push_o = s_tvalid_i && !q_full_i && known;

endmodule

### hdl/ssfs_queue.sv
// Small command queue between front and back end.
module ssfs_queue #(
  parameter int unsigned Depth = ssfs_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ssfs_pkg::cmd_t   cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output ssfs_pkg::cmd_t   cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  ssfs_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cmd_i;
  end

endmodule

### hdl/ssfs_back.sv
// Back end: holds the shown bytes and sequences the wire bytes of each command.
module ssfs_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ssfs_pkg::cfg_t   cfg_i,
  input  logic             q_valid_i,
  input  ssfs_pkg::cmd_t   q_cmd_i,
  output logic             q_pop_o,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [7:0]       m_byte_o,
  output logic [2:0]       m_flags_o,
  output logic             m_last_o
);

  logic [3:0][7:0] shown_q, shown_d;
  logic            busy_q, busy_d;
  logic [3:0]      step_q, step_d;
  ssfs_pkg::op_e   op_q;
  logic [1:0]      pos_q;
  logic [7:0]      nb_q, ob_q;

  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q;
  logic [2:0]      out_flags_q;
  logic            out_last_q;

  logic            out_ready, emit;
  logic [7:0]      byt, fseg, ctrl;
  logic [1:0]      fpos, qidx;
  logic [1:0]      frame, slot;
  logic            st, sp, pa, lst;

  assign out_ready = !out_valid_q || m_tready_i;
  assign emit      = busy_q && out_ready;
  assign q_pop_o   = !busy_q && q_valid_i;
  assign frame     = step_q[3:2];
  assign slot      = step_q[1:0];
  assign ctrl      = ssfs_pkg::CmdCtrlBase + {5'd0, cfg_i.brightness};
  assign qidx      = step_q[1:0] - 2'd2;

  // segment byte of the current single-position frame
  always_comb begin
    fpos = pos_q;
    fseg = nb_q;
    unique case (op_q)
      ssfs_pkg::OP_CLEAR: begin
        fpos = frame;
        fseg = 8'h00;
      end
      ssfs_pkg::OP_SCROLL: begin
        unique case (frame)
          2'd0:    fseg = {1'b0, ob_q[0], 1'b0, ob_q[5], ob_q[6], ob_q[1], 2'b00};
          2'd1:    fseg = {4'd0, ob_q[0], 2'b00, nb_q[3]};
          2'd2:    fseg = {1'b0, nb_q[3], nb_q[4], 3'b000, nb_q[2], nb_q[6]};
          default: fseg = nb_q;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    byt = 8'h00;
    st  = 1'b0;
    sp  = 1'b0;
    pa  = 1'b0;
    lst = 1'b0;
    if (op_q == ssfs_pkg::OP_QUAD) begin
      if (step_q == 4'd0) begin
        byt = ssfs_pkg::CmdDataAuto;
        st  = 1'b1;
        sp  = 1'b1;
      end else if (step_q == 4'd1) begin
        byt = cfg_i.start_address;
        st  = 1'b1;
      end else if (step_q == 4'd6) begin
        byt = ctrl;
        st  = 1'b1;
        sp  = 1'b1;
        lst = 1'b1;
      end else begin
        byt = shown_q[qidx] + cfg_i.point_mask;
        sp  = (step_q == 4'd5);
      end
    end else begin
      unique case (slot)
        2'd0: begin
          byt = ssfs_pkg::CmdDataFixed;
          st  = 1'b1;
          sp  = 1'b1;
        end
        2'd1: begin
          byt = ssfs_pkg::CmdAddrBase | {6'd0, fpos};
          st  = 1'b1;
        end
        2'd2: begin
          byt = fseg + cfg_i.point_mask;
          sp  = 1'b1;
        end
        default: begin
          byt = ctrl;
          st  = 1'b1;
          sp  = 1'b1;
          pa  = (op_q == ssfs_pkg::OP_SCROLL) && (frame != 2'd3);
          lst = (op_q == ssfs_pkg::OP_SINGLE) || (frame == 2'd3);
        end
      endcase
    end
  end

  always_comb begin
    shown_d     = shown_q;
    busy_d      = busy_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (m_tready_i) out_valid_d = 1'b0;
    if (q_pop_o) begin
      busy_d = 1'b1;
      step_d = '0;
      unique case (q_cmd_i.op)
        ssfs_pkg::OP_SINGLE,
        ssfs_pkg::OP_SCROLL: shown_d[q_cmd_i.pos] = q_cmd_i.nb;
        ssfs_pkg::OP_QUAD:   if (q_cmd_i.store) shown_d = q_cmd_i.segs;
        ssfs_pkg::OP_CLEAR:  shown_d = '0;
        default: ;
      endcase
    end else if (emit) begin
      out_valid_d = 1'b1;
      step_d      = step_q + 1'b1;
      if (lst) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shown_q     <= '0;
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      shown_q     <= shown_d;
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      op_q  <= q_cmd_i.op;
      pos_q <= q_cmd_i.pos;
      nb_q  <= q_cmd_i.nb;
      ob_q  <= shown_q[q_cmd_i.pos];
    end
    if (emit) begin
      out_byte_q  <= byt;
      out_flags_q <= {pa, sp, st};
      out_last_q  <= lst;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_byte_o   = out_byte_q;
  assign m_flags_o  = out_flags_q;
  assign m_last_o   = out_last_q;

endmodule

### hdl/seven_segment_frame_sequencer.sv
// Seven-segment frame sequencer: top level.
// A request passes the command queue and the back end's command registers; wire bytes leave from an output register.
// One wire byte per cycle while the output is not stalled; a request gives 4, 7 or 16
// bytes, and the back end emits none while it loads the next command from the queue.
// Front end and back end are parted by a command queue of QueueDepth entries.
// Reset: queue emptied, shown bytes zero, registers 0, 192 and 0.
module seven_segment_frame_sequencer #(
  parameter int unsigned QueueDepth = ssfs_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] position, [5:2] digit_code, [13:6] seg_a, [21:14] seg_b,
  // [29:22] seg_c, [37:30] seg_d, [39:38] zero
  input  logic [39:0] s_axis_tdata_i,
  // [2:0] kind
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] wire_byte
  output logic [7:0]  m_axis_tdata_o,
  // [0] start_before, [1] stop_after, [2] pause_after
  output logic [2:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ssfs_pkg::cfg_t  cfg;
  ssfs_pkg::cmd_t  push_cmd, pop_cmd;
  logic            q_full, q_push, q_valid, q_pop;
  logic [3:0][7:0] segs;

  assign segs = {s_axis_tdata_i[37:30], s_axis_tdata_i[29:22],
                 s_axis_tdata_i[21:14], s_axis_tdata_i[13:6]};

  ssfs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ssfs_front u_front (
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_kind_i   (s_axis_tuser_i),
    .s_pos_i    (s_axis_tdata_i[1:0]),
    .s_digit_i  (s_axis_tdata_i[5:2]),
    .s_segs_i   (segs),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  ssfs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (pop_cmd)
  );

  ssfs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_valid_i  (q_valid),
    .q_cmd_i    (pop_cmd),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_byte_o   (m_axis_tdata_o),
    .m_flags_o  (m_axis_tuser_o),
    .m_last_o   (m_axis_tlast_o)
  );

endmodule

### verif/tb_top.sv
// Self-checking testbench of the seven-segment frame sequencer: stream and register port.
module tb_top;

  localparam logic [2:0] KindUnused = 3'd7;  // no frame, request dropped
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned PhaseItems = 48;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned NumDirected = 21;

  localparam logic [7:0] DigitSegs [0:15] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
    8'h7f, 8'h6f, 8'h00, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] pos;
    logic [3:0] code;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d;
  } req_t;

  typedef struct packed {
    logic [7:0] wbyte;
    logic       start;
    logic       stop;
    logic       pause;
    logic       last;
  } wire_txn_t;

  // typed rows fix the data byte of a single-position frame
  typedef struct packed {
    req_t       rq;
    logic       typed;
    logic [7:0] data_byte;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;
  logic [2:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  seven_segment_frame_sequencer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // shadow of the block's state and registers
  logic [7:0] shown [0:3] = '{8'h00, 8'h00, 8'h00, 8'h00};
  logic [2:0] bri_q   = ssfs_pkg::BrightnessReset;
  logic [7:0] saddr_q = ssfs_pkg::StartAddrReset;
  logic [7:0] pmask_q = ssfs_pkg::PointMaskReset;

  wire_txn_t req_bytes_q [$];
  wire_txn_t wire_q [$];
  int unsigned errors = 0;
  int unsigned idle_cnt = 0;
  bit snd_fast = 1'b0;
  bit rcv_fast = 1'b0;
  bit hold_long_req = 1'b0;

  dir_row_t dir_tab [0:NumDirected-1] = '{
    '{'{ssfs_pkg::KIND_DIGIT,      2'd0, 4'd0,  8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 8'h3f},
    '{'{ssfs_pkg::KIND_DIGIT,      2'd1, 4'd8,  8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 8'h7f},
    '{'{ssfs_pkg::KIND_DIGIT,      2'd2, 4'd11, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 8'h40},
    '{'{ssfs_pkg::KIND_DIGIT,      2'd3, 4'd10, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1, 8'h00},
    '{'{ssfs_pkg::KIND_DIGIT,      2'd0, 4'd15, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 8'h00},
    '{'{ssfs_pkg::KIND_DIGIT,      2'd1, 4'd12, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 8'h00},
    '{'{ssfs_pkg::KIND_DIGIT,      2'd2, 4'd9,  8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 8'h6f},
    '{'{ssfs_pkg::KIND_RAW_ONE,    2'd3, 4'd0,  8'hff, 8'h00, 8'h00, 8'h00}, 1'b1, 8'hff},
    '{'{ssfs_pkg::KIND_RAW_ONE,    2'd0, 4'd15, 8'h00, 8'hff, 8'hff, 8'hff}, 1'b1, 8'h00},
    '{'{ssfs_pkg::KIND_RAW_FOUR,   2'd0, 4'd0,  8'h00, 8'hff, 8'h55, 8'haa}, 1'b0, 8'h00},
    '{'{ssfs_pkg::KIND_REFRESH,    2'd3, 4'd0,  8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00},
    '{'{KindUnused,                2'd3, 4'd15, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, 8'h00},
    '{'{ssfs_pkg::KIND_SCROLL_DIG, 2'd1, 4'd8,  8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00},
    '{'{ssfs_pkg::KIND_SCROLL_RAW, 2'd3, 4'd0,  8'hff, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00},
    '{'{ssfs_pkg::KIND_SCROLL_RAW, 2'd0, 4'd0,  8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00},
    '{'{ssfs_pkg::KIND_SCROLL_DIG, 2'd2, 4'd15, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00},
    '{'{ssfs_pkg::KIND_CLEAR,      2'd0, 4'd0,  8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00},
    '{'{ssfs_pkg::KIND_REFRESH,    2'd0, 4'd0,  8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00},
    '{'{ssfs_pkg::KIND_RAW_FOUR,   2'd2, 4'd0,  8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, 8'h00},
    '{'{ssfs_pkg::KIND_SCROLL_RAW, 2'd3, 4'd0,  8'ha5, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00},
    '{'{ssfs_pkg::KIND_RAW_ONE,    2'd2, 4'd0,  8'h5a, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00}
  };

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void push_byte(logic [7:0] b, logic st, logic sp, logic pa);
    req_bytes_q.push_back('{b, st, sp, pa, 1'b0});
  endfunction

  function automatic void single_frame(logic [1:0] p, logic [7:0] seg, logic pa);
    shown[p] = seg;
    push_byte(ssfs_pkg::CmdDataFixed, 1'b1, 1'b1, 1'b0);
    push_byte(ssfs_pkg::CmdAddrBase | {6'd0, p}, 1'b1, 1'b0, 1'b0);
    push_byte(seg + pmask_q, 1'b0, 1'b1, 1'b0);
    push_byte(ssfs_pkg::CmdCtrlBase + {5'd0, bri_q}, 1'b1, 1'b1, pa);
  endfunction

  function automatic void quad_frame();
    push_byte(ssfs_pkg::CmdDataAuto, 1'b1, 1'b1, 1'b0);
    push_byte(saddr_q, 1'b1, 1'b0, 1'b0);
    for (int i = 0; i < 4; i++)
      push_byte(shown[i] + pmask_q, 1'b0, i == 3, 1'b0);
    push_byte(ssfs_pkg::CmdCtrlBase + {5'd0, bri_q}, 1'b1, 1'b1, 1'b0);
  endfunction

  // old glyph rotated, a blend of old and new, new rotated, then the new glyph
  function automatic void scroll_frames(logic [1:0] p, logic [7:0] nb);
    logic [7:0] ob;
    ob = shown[p];
    single_frame(p, {1'b0, ob[0], 1'b0, ob[5], ob[6], ob[1], 2'b00}, 1'b1);
    single_frame(p, {4'b0000, ob[0], 2'b00, nb[3]}, 1'b1);
    single_frame(p, {1'b0, nb[3], nb[4], 3'b000, nb[2], nb[6]}, 1'b1);
    single_frame(p, nb, 1'b0);
  endfunction

  function automatic void predict_wire_bytes(req_t rq);
    wire_txn_t t;
    req_bytes_q.delete();
    case (rq.kind)
      ssfs_pkg::KIND_DIGIT:      single_frame(rq.pos, DigitSegs[rq.code], 1'b0);
      ssfs_pkg::KIND_RAW_ONE:    single_frame(rq.pos, rq.a, 1'b0);
      ssfs_pkg::KIND_RAW_FOUR: begin
        shown[0] = rq.a;
        shown[1] = rq.b;
        shown[2] = rq.c;
        shown[3] = rq.d;
        quad_frame();
      end
      ssfs_pkg::KIND_REFRESH:    quad_frame();
      ssfs_pkg::KIND_CLEAR: begin
        for (int i = 0; i < 4; i++)
          single_frame(i[1:0], 8'h00, 1'b0);
      end
      ssfs_pkg::KIND_SCROLL_DIG: scroll_frames(rq.pos, DigitSegs[rq.code]);
      ssfs_pkg::KIND_SCROLL_RAW: scroll_frames(rq.pos, rq.a);
      default: ;
    endcase
    if (req_bytes_q.size() > 0) begin
      t = req_bytes_q[req_bytes_q.size()-1];
      t.last = 1'b1;
      req_bytes_q[req_bytes_q.size()-1] = t;
    end
  endfunction

  function automatic req_t rand_req();
    req_t rq;
    int unsigned r;
    r = $urandom_range(0, 39);
    rq.kind = (r == 0) ? KindUnused : 3'(r % 7);
    rq.pos  = 2'($urandom_range(0, 3));
    rq.code = 4'($urandom_range(0, 15));
    rq.a = 8'($urandom);
    rq.b = 8'($urandom);
    rq.c = 8'($urandom);
    rq.d = 8'($urandom);
    return rq;
  endfunction

  function automatic void cmp_field(string what, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, act_v);
    end
  endfunction

  // called at the edge that follows a previous transaction or register access
  task automatic send_req(req_t rq, logic typed, logic [7:0] data_byte);
    int unsigned gap;
    wire_txn_t t;
    gap = snd_fast ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= rq.kind;
    s_axis_tdata_i  <= {2'b00, rq.d, rq.c, rq.b, rq.a, rq.code, rq.pos};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_wire_bytes(rq);
    if (typed && req_bytes_q.size() > 2) begin
      t = req_bytes_q[2];
      t.wbyte = data_byte;
      req_bytes_q[2] = t;
    end
    foreach (req_bytes_q[i]) wire_q.push_back(req_bytes_q[i]);
  endtask

  task automatic reg_write(ssfs_pkg::reg_e r, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      ssfs_pkg::REG_BRIGHTNESS: bri_q   = v[2:0];
      ssfs_pkg::REG_START_ADDR: saddr_q = v[7:0];
      ssfs_pkg::REG_POINT_MASK: pmask_q = v[7:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic reg_read_check(ssfs_pkg::reg_e r, logic [7:0] exp_v, logic [7:0] mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cmp_field("register read", exp_v, prdata[7:0] & mask);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_and_settle();
    s_axis_tvalid_i <= 1'b0;
    while (wire_q.size() != 0) @(posedge clk_i);
    // a dropped request never enters the block and yields no wire bytes
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [2:0] bri, logic [7:0] sa, logic [7:0] pm);
    reg_write(ssfs_pkg::REG_BRIGHTNESS, {29'd0, bri});
    reg_write(ssfs_pkg::REG_START_ADDR, {24'd0, sa});
    reg_write(ssfs_pkg::REG_POINT_MASK, {24'd0, pm});
    reg_read_check(ssfs_pkg::REG_BRIGHTNESS, {5'd0, bri}, 8'h07);
    reg_read_check(ssfs_pkg::REG_START_ADDR, sa, 8'hff);
    reg_read_check(ssfs_pkg::REG_POINT_MASK, pm, 8'hff);
  endtask

  task automatic check_wire_txn();
    wire_txn_t e;
    if (wire_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected wire byte, expected none, got %h", $time, m_axis_tdata_o);
    end else begin
      e = wire_q.pop_front();
      cmp_field("wire_byte", e.wbyte, m_axis_tdata_o);
      cmp_field("start_before", {7'd0, e.start}, {7'd0, m_axis_tuser_o[0]});
      cmp_field("stop_after", {7'd0, e.stop}, {7'd0, m_axis_tuser_o[1]});
      cmp_field("pause_after", {7'd0, e.pause}, {7'd0, m_axis_tuser_o[2]});
      cmp_field("last", {7'd0, e.last}, {7'd0, m_axis_tlast_o});
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) check_wire_txn();
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cnt <= 0;
      else
        idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // output side back-pressure
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_long_req) begin
        hold_long_req = 1'b0;
        stall = LongHoldCycles;
      end else begin
        stall = rcv_fast ? 0 : $urandom_range(0, 15);
      end
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  initial begin
    req_t rq;
    int unsigned n;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++)
      send_req(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].data_byte);
    drain_and_settle();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: set_regs(3'd7, 8'hff, 8'hff);
        1: set_regs(3'd0, 8'h00, 8'h01);
        default: set_regs(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
      endcase
      snd_fast = (ph == 1) || (ph == 2);
      rcv_fast = (ph == 1);
      // fill the block while the output is held off
      if (ph == 2) hold_long_req = 1'b1;
      n = 0;
      while (n < PhaseItems) begin
        rq = rand_req();
        send_req(rq, 1'b0, 8'h00);
        if (rq.kind != KindUnused) n++;
      end
      drain_and_settle();
    end

    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### files.f
hdl/ssfs_pkg.sv
hdl/ssfs_regs.sv
hdl/ssfs_front.sv
hdl/ssfs_queue.sv
hdl/ssfs_back.sv
hdl/seven_segment_frame_sequencer.sv
verif/tb_top.sv
